[rtl/sap_pkg.sv]
// ---------------------------------------------------------------------------
// sap_pkg: shared types and constants
// Action, result-kind and register codes, the command descriptor carried
// from the front end to the frame sequencer, and the play-frame byte helper.
// ---------------------------------------------------------------------------
package sap_pkg;

  localparam logic [1:0] ACT_PLAY = 2'd0;
  localparam logic [1:0] ACT_RX   = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_RX   = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_FOLDER  = 2'd1;
  localparam logic [1:0] REG_VERSION = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd30000;
  localparam logic [7:0]  FOLDER_RST  = 8'h01;
  localparam logic [7:0]  VERSION_RST = 8'hFF;

  localparam logic [7:0] SOF_BYTE   = 8'h7E;
  localparam logic [7:0] EOF_BYTE   = 8'hEF;
  localparam logic [7:0] LEN_BYTE   = 8'h06;
  localparam logic [7:0] PLAY_CMD   = 8'h0F;
  localparam logic [7:0] DONE_CMD   = 8'h3D;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  localparam int FRAME_LEN = 10;
  localparam logic [3:0] WIN_FULL = 4'd10;

  // Sequencer steps: step 0 is the event result, steps 1..10 the frame bytes
  localparam logic [3:0] STEP_EVT   = 4'd0;
  localparam logic [3:0] STEP_FIRST = 4'd1;
  localparam logic [3:0] STEP_LAST  = 4'd10;

  localparam int DQ_DEPTH = 4;
  localparam int DQ_AW    = 2;

  typedef struct packed {
    logic [15:0] timeout;
    logic [7:0]  folder;
    logic [7:0]  version;
  } sap_cfg_t;

  typedef struct packed {
    logic       ev_vld;
    logic [1:0] ev_kind;
    logic [7:0] ev_cmd;
    logic [7:0] ev_fb;
    logic [7:0] ev_ph;
    logic [7:0] ev_pl;
    logic       ev_busy;
    logic       la_vld;
    logic [7:0] la_track;
  } sap_desc_t;

  // Byte of the outgoing play frame for sequencer step 1..10
  function automatic logic [7:0] frame_byte(input logic [3:0] step,
                                            input logic [7:0] version,
                                            input logic [7:0] folder,
                                            input logic [7:0] track);
    logic [9:0]  sum;
    logic [15:0] ck;
    sum = {2'b00, version} + {2'b00, folder} + {2'b00, track}
        + {2'b00, LEN_BYTE} + {2'b00, PLAY_CMD};
    ck  = 16'd0 - {6'd0, sum};
    unique case (step)
      4'd1:    frame_byte = SOF_BYTE;
      4'd2:    frame_byte = version;
      4'd3:    frame_byte = LEN_BYTE;
      4'd4:    frame_byte = PLAY_CMD;
      4'd5:    frame_byte = ZERO_BYTE;
      4'd6:    frame_byte = folder;
      4'd7:    frame_byte = track;
      4'd8:    frame_byte = ck[15:8];
      4'd9:    frame_byte = ck[7:0];
      4'd10:   frame_byte = EOF_BYTE;
      default: frame_byte = ZERO_BYTE;
    endcase
  endfunction

endpackage

[rtl/sap_if.sv]
// ---------------------------------------------------------------------------
// sap_if: channel interfaces
// Input item, result item and register write channels, valid/ready each.
// ---------------------------------------------------------------------------
interface sap_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] track;
  logic [7:0] rx_byte;
  modport source (output valid, action, track, rx_byte, input ready);
  modport sink   (input valid, action, track, rx_byte, output ready);
endinterface

interface sap_out_if #(parameter int CNT_W = 5);
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       tx_byte;
  logic             last;
  logic [7:0]       rx_command;
  logic [7:0]       rx_feedback;
  logic [7:0]       rx_param_high;
  logic [7:0]       rx_param_low;
  logic             player_busy;
  logic [CNT_W-1:0] queue_count;
  modport source (output valid, kind, tx_byte, last, rx_command, rx_feedback,
                  rx_param_high, rx_param_low, player_busy, queue_count,
                  input ready);
  modport sink   (input valid, kind, tx_byte, last, rx_command, rx_feedback,
                  rx_param_high, rx_param_low, player_busy, queue_count,
                  output ready);
endinterface

interface sap_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/serial_audio_player_controller.sv]
// ---------------------------------------------------------------------------
// serial_audio_player_controller: serial audio-player command controller
// Queues play requests, emits 10-byte play frames when the player is free,
// checks frames received from the player and times out busy playback.
// ---------------------------------------------------------------------------
// Path: an item's first result is held in the descriptor register, then the
//   descriptor queue, then the result register, before it is valid on out_ch.
// Throughput: one item per cycle into the front end, one result per cycle out,
//   while neither side stalls; a frame launch holds the result side for its
//   ten frame bytes and any event result, and a 4-entry queue absorbs bursts.
// Reset: rst_n low clears pointers, busy, timer, window fill, handshake state;
//   registers return to 30000 ticks, folder 1, version FF.
module serial_audio_player_controller import sap_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sap_in_if.sink    in_ch,
  sap_out_if.source out_ch,
  sap_cfg_if.sink   cfg_ch
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = $bits(sap_desc_t) + 2 * CW;

  sap_cfg_t      cfg_r;
  logic          f_vld, f_rdy;
  sap_desc_t     f_dsc;
  logic [CW-1:0] f_ev_cnt, f_la_cnt;
  logic [DW-1:0] q_wr, q_rd;
  logic          q_vld, q_pop;
  sap_desc_t     b_dsc;
  logic [CW-1:0] b_ev_cnt, b_la_cnt;

  // Register writes are always taken; writes beyond the list are dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout <= TIMEOUT_RST;
      cfg_r.folder  <= FOLDER_RST;
      cfg_r.version <= VERSION_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_TIMEOUT: cfg_r.timeout <= cfg_ch.data;
        REG_FOLDER:  cfg_r.folder  <= cfg_ch.data[7:0];
        REG_VERSION: cfg_r.version <= cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classify each transfer, update queue, busy and window state
  sap_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .dsc_vld    (f_vld),
    .dsc_rdy    (f_rdy),
    .dsc        (f_dsc),
    .dsc_ev_cnt (f_ev_cnt),
    .dsc_la_cnt (f_la_cnt)
  );

  assign q_wr = {f_dsc, f_ev_cnt, f_la_cnt};

  // Descriptor queue: lets the front keep accepting while frames drain
  sap_desc_fifo #(.W(DW)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_vld  (f_vld),
    .wr_rdy  (f_rdy),
    .wr_data (q_wr),
    .rd_vld  (q_vld),
    .rd_rdy  (q_pop),
    .rd_data (q_rd)
  );

  assign {b_dsc, b_ev_cnt, b_la_cnt} = q_rd;

  // Back end: advance through event result and frame bytes
  sap_back #(.CW(CW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .dsc_vld    (q_vld),
    .dsc_pop    (q_pop),
    .dsc        (b_dsc),
    .dsc_ev_cnt (b_ev_cnt),
    .dsc_la_cnt (b_la_cnt),
    .out_ch     (out_ch)
  );

  // Every frame byte reports a busy player
  a_tx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind == KIND_TX) |-> out_ch.player_busy)
    else $error("frame byte transferred with player idle");

  // A queued descriptor always carries at least one result
  a_desc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld |-> (b_dsc.ev_vld || b_dsc.la_vld))
    else $error("empty descriptor in queue");

  // A held result stays put while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.tx_byte)
      && $stable(out_ch.kind) && $stable(out_ch.last))
    else $error("result changed under stall");

  // Front end stalls only while its descriptor waits on a full queue
  a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> f_vld && !f_rdy)
    else $error("input stalled without back pressure");

endmodule

[rtl/sap_front.sv]
// ---------------------------------------------------------------------------
// sap_front: request front end
// Track queue, player busy/timer state and receive window. Classifies each
// item combinationally and hands a command descriptor to the sequencer.
// ---------------------------------------------------------------------------
module sap_front import sap_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int QW = $clog2(QUEUE_DEPTH),
  parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  sap_in_if.sink          in_ch,
  input  sap_cfg_t        cfg,
  output logic            dsc_vld,
  input  logic            dsc_rdy,
  output sap_desc_t       dsc,
  output logic [CW-1:0]   dsc_ev_cnt,
  output logic [CW-1:0]   dsc_la_cnt
);

  logic [7:0]    q_mem [QUEUE_DEPTH];
  logic [7:0]    rd_data_r;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] fill_r, fill_nxt, fill_mid;
  logic          busy_r, busy_nxt, busy_mid;
  logic [15:0]   timer_r, timer_nxt, timer_inc;
  logic [7:0]    win_r [FRAME_LEN];
  logic [7:0]    win_nxt [FRAME_LEN];
  logic [3:0]    wfill_r, wfill_nxt;
  logic [10:0]   wsum;
  logic [15:0]   wck;
  logic          win_ok;
  logic          acc, wr_en, la_go;
  sap_desc_t     d_r, d_nxt;
  logic          b_vld_r, b_vld_nxt;
  logic          byp_r;
  logic [7:0]    byp_trk_r;
  logic [CW-1:0] ev_cnt_r, la_cnt_r;

  assign in_ch.ready = !b_vld_r || dsc_rdy;
  assign acc         = in_ch.valid && in_ch.ready;

  // Window shifts on every accepted received byte; contents only matter once ten bytes are in
  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      win_nxt[i] = win_r[i + 1];
    end
    win_nxt[FRAME_LEN - 1] = in_ch.rx_byte;
    wfill_nxt = (wfill_r == WIN_FULL) ? WIN_FULL : wfill_r + 4'd1;
    wsum = {3'd0, win_nxt[1]} + {3'd0, win_nxt[2]} + {3'd0, win_nxt[3]}
         + {3'd0, win_nxt[4]} + {3'd0, win_nxt[5]} + {3'd0, win_nxt[6]};
    wck  = 16'd0 - {5'd0, wsum};
    win_ok = (wfill_nxt == WIN_FULL) && (win_nxt[0] == SOF_BYTE)
          && (win_nxt[9] == EOF_BYTE) && ({win_nxt[7], win_nxt[8]} == wck);
  end

  assign timer_inc = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;

  always_comb begin
    wr_en     = 1'b0;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_mid  = fill_r;
    busy_mid  = busy_r;
    timer_nxt = timer_r;
    d_nxt     = '0;
    unique case (in_ch.action)
      ACT_PLAY: begin
        if (fill_r == CW'(QUEUE_DEPTH)) begin
          d_nxt.ev_vld  = 1'b1;
          d_nxt.ev_kind = KIND_DROP;
        end else begin
          wr_en    = 1'b1;
          head_nxt = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
          fill_mid = fill_r + CW'(1);
        end
      end
      ACT_RX: begin
        if (win_ok) begin
          d_nxt.ev_vld  = 1'b1;
          d_nxt.ev_kind = KIND_RX;
          d_nxt.ev_cmd  = win_nxt[3];
          d_nxt.ev_fb   = win_nxt[4];
          d_nxt.ev_ph   = win_nxt[5];
          d_nxt.ev_pl   = win_nxt[6];
          if (win_nxt[3] == DONE_CMD) begin
            busy_mid = 1'b0;
          end
        end
      end
      ACT_TICK: begin
        if (busy_r) begin
          timer_nxt = timer_inc;
          if (timer_inc > cfg.timeout) begin
            busy_mid = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    d_nxt.ev_busy = busy_mid;
    // Launch the oldest track once the player is free
    la_go    = !busy_mid && (fill_mid != '0);
    fill_nxt = fill_mid;
    busy_nxt = busy_mid;
    if (la_go) begin
      tail_nxt     = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QW'(1);
      fill_nxt     = fill_mid - CW'(1);
      busy_nxt     = 1'b1;
      timer_nxt    = '0;
      d_nxt.la_vld = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      q_mem[head_r] <= in_ch.track;
    end
    if (acc && la_go) begin
      rd_data_r <= q_mem[tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      busy_r  <= 1'b0;
      timer_r <= '0;
      wfill_r <= '0;
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= b_vld_nxt;
      if (acc) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        fill_r  <= fill_nxt;
        busy_r  <= busy_nxt;
        timer_r <= timer_nxt;
        if (in_ch.action == ACT_RX) begin
          wfill_r <= win_ok ? 4'd0 : wfill_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_ch.action == ACT_RX) begin
      win_r <= win_nxt;
    end
    if (acc) begin
      d_r       <= d_nxt;
      byp_r     <= wr_en && (head_r == tail_r);
      byp_trk_r <= in_ch.track;
      ev_cnt_r  <= fill_mid;
      la_cnt_r  <= fill_nxt;
    end
  end

  // Hold the descriptor stage until the queue takes it
  assign b_vld_nxt = acc ? (d_nxt.ev_vld || d_nxt.la_vld) : (b_vld_r && !dsc_rdy);

  always_comb begin
    dsc          = d_r;
    dsc.la_track = byp_r ? byp_trk_r : rd_data_r;
  end
  assign dsc_vld    = b_vld_r;
  assign dsc_ev_cnt = ev_cnt_r;
  assign dsc_la_cnt = la_cnt_r;

endmodule

[rtl/sap_desc_fifo.sv]
// ---------------------------------------------------------------------------
// sap_desc_fifo: descriptor queue
// Short register queue between the front end and the frame sequencer.
// ---------------------------------------------------------------------------
module sap_desc_fifo import sap_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_vld,
  output logic         wr_rdy,
  input  logic [W-1:0] wr_data,
  output logic         rd_vld,
  input  logic         rd_rdy,
  output logic [W-1:0] rd_data
);

  logic [W-1:0]     ent_r [DQ_DEPTH];
  logic [DQ_AW-1:0] wp_r, rp_r;
  logic [DQ_AW:0]   cnt_r;
  logic             push, pop;

  assign wr_rdy  = (cnt_r != (DQ_AW + 1)'(DQ_DEPTH));
  assign rd_vld  = (cnt_r != '0);
  assign push    = wr_vld && wr_rdy;
  assign pop     = rd_vld && rd_rdy;
  assign rd_data = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + DQ_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + DQ_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (DQ_AW + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (DQ_AW + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/sap_back.sv]
// ---------------------------------------------------------------------------
// sap_back: frame sequencer
// Walks each descriptor through its event result, its ten play-frame bytes or
// both, into a registered result slot.
// ---------------------------------------------------------------------------
module sap_back import sap_pkg::*; #(
  parameter int CW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sap_cfg_t      cfg,
  input  logic          dsc_vld,
  output logic          dsc_pop,
  input  sap_desc_t     dsc,
  input  logic [CW-1:0] dsc_ev_cnt,
  input  logic [CW-1:0] dsc_la_cnt,
  sap_out_if.source     out_ch
);

  logic        ov_r;
  logic        started_r;
  logic [3:0]  step_r, step;
  logic        take, is_last;

  assign take    = dsc_vld && (!ov_r || out_ch.ready);
  assign step    = started_r ? step_r : (dsc.ev_vld ? STEP_EVT : STEP_FIRST);
  assign is_last = (step == STEP_EVT) ? !dsc.la_vld : (step == STEP_LAST);
  assign dsc_pop = take && is_last;

  assign out_ch.valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r      <= 1'b0;
      started_r <= 1'b0;
      step_r    <= STEP_EVT;
    end else begin
      if (take) begin
        ov_r      <= 1'b1;
        started_r <= !is_last;
        step_r    <= step + 4'd1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.last <= is_last;
      if (step == STEP_EVT) begin
        out_ch.kind          <= dsc.ev_kind;
        out_ch.tx_byte       <= ZERO_BYTE;
        out_ch.rx_command    <= dsc.ev_cmd;
        out_ch.rx_feedback   <= dsc.ev_fb;
        out_ch.rx_param_high <= dsc.ev_ph;
        out_ch.rx_param_low  <= dsc.ev_pl;
        out_ch.player_busy   <= dsc.ev_busy;
        out_ch.queue_count   <= dsc_ev_cnt;
      end else begin
        out_ch.kind          <= KIND_TX;
        out_ch.tx_byte       <= frame_byte(step, cfg.version, cfg.folder, dsc.la_track);
        out_ch.rx_command    <= ZERO_BYTE;
        out_ch.rx_feedback   <= ZERO_BYTE;
        out_ch.rx_param_high <= ZERO_BYTE;
        out_ch.rx_param_low  <= ZERO_BYTE;
        out_ch.player_busy   <= 1'b1;
        out_ch.queue_count   <= dsc_la_cnt;
      end
    end
  end

endmodule

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the serial audio-player controller
// Drives play requests, received bytes and ticks over the input channel,
// rewrites the registers between phases, and checks every result against
// a frame scoreboard that tracks the track queue, the busy timer and the
// receive window on its own.
// ---------------------------------------------------------------------------
module tb_top import sap_pkg::*; ();

  localparam int QDEPTH        = 16;
  localparam logic [1:0] ACT_NONE = 2'd3;   // unused action code, ignored by the block
  localparam logic [1:0] REG_NONE = 2'd3;   // register index with no register behind it
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int TICK_RUN      = 8;         // stays far below the largest timeout
  localparam int PRINT_CAP     = 50;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [7:0] rx_command;
    logic [7:0] rx_feedback;
    logic [7:0] rx_param_high;
    logic [7:0] rx_param_low;
    logic       player_busy;
    logic [4:0] queue_count;
  } result_t;

  // Tracks the block's state and holds the results each accepted item causes
  class frame_scoreboard;
    logic [15:0] timeout_ticks;
    logic [7:0]  folder;
    logic [7:0]  version;
    logic [7:0]  track_store [QDEPTH];
    logic [3:0]  rd_ptr;
    logic [3:0]  wr_ptr;
    int unsigned waiting;
    logic        busy;
    logic [15:0] timer;
    logic [7:0]  window [FRAME_LEN];
    int unsigned win_fill;
    result_t     pending_results [$];
    int          errors;
    int          checked;

    function new();
      timeout_ticks = TIMEOUT_RST;
      folder        = FOLDER_RST;
      version       = VERSION_RST;
      rd_ptr        = 4'd0;
      wr_ptr        = 4'd0;
      waiting       = 0;
      busy          = 1'b0;
      timer         = 16'd0;
      foreach (window[i]) window[i] = 8'h00;
      win_fill      = 0;
      errors        = 0;
      checked       = 0;
    endfunction

    static function logic [15:0] checksum16(input logic [7:0] b1, input logic [7:0] b2,
                                            input logic [7:0] b3, input logic [7:0] b4,
                                            input logic [7:0] b5, input logic [7:0] b6);
      logic [15:0] sum;
      sum = 16'(b1) + 16'(b2) + 16'(b3) + 16'(b4) + 16'(b5) + 16'(b6);
      return 16'h0000 - sum;
    endfunction

    function void apply_register(input logic [1:0] idx, input logic [15:0] data);
      case (idx)
        REG_TIMEOUT: timeout_ticks = data;
        REG_FOLDER:  folder  = data[7:0];
        REG_VERSION: version = data[7:0];
        default: ;
      endcase
    endfunction

    function void add_result(input logic [1:0] kind, input logic [7:0] tx,
                             input logic [7:0] cmd, input logic [7:0] fb,
                             input logic [7:0] ph, input logic [7:0] pl);
      result_t r;
      r.kind          = kind;
      r.tx_byte       = tx;
      r.last          = 1'b0;
      r.rx_command    = cmd;
      r.rx_feedback   = fb;
      r.rx_param_high = ph;
      r.rx_param_low  = pl;
      r.player_busy   = busy;
      r.queue_count   = 5'(waiting);
      pending_results.push_back(r);
    endfunction

    function bit window_ok();
      if (win_fill < FRAME_LEN) return 1'b0;
      if (window[0] != SOF_BYTE || window[9] != EOF_BYTE) return 1'b0;
      return {window[7], window[8]} ==
             checksum16(window[1], window[2], window[3], window[4], window[5], window[6]);
    endfunction

    function void predict_item(input logic [1:0] act, input logic [7:0] trk,
                               input logic [7:0] rxb);
      int          first;
      logic [7:0]  rx_frame [FRAME_LEN];
      logic [7:0]  tx_frame [FRAME_LEN];
      logic [15:0] ck;
      first = pending_results.size();
      if (act == ACT_NONE) return;
      case (act)
        ACT_PLAY: begin
          if (waiting >= QDEPTH) begin
            add_result(KIND_DROP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
          end else begin
            track_store[wr_ptr] = trk;
            wr_ptr  = wr_ptr + 4'd1;
            waiting = waiting + 1;
          end
        end
        ACT_RX: begin
          if (win_fill < FRAME_LEN) begin
            window[win_fill] = rxb;
            win_fill = win_fill + 1;
          end else begin
            for (int i = 0; i < FRAME_LEN - 1; i++) window[i] = window[i+1];
            window[FRAME_LEN-1] = rxb;
          end
          if (window_ok()) begin
            rx_frame = window;
            foreach (window[i]) window[i] = 8'h00;
            win_fill = 0;
            if (rx_frame[3] == DONE_CMD) busy = 1'b0;
            add_result(KIND_RX, 8'h00, rx_frame[3], rx_frame[4], rx_frame[5], rx_frame[6]);
          end
        end
        default: begin
          if (busy) begin
            if (timer != 16'hFFFF) timer = timer + 16'd1;
            if (timer > timeout_ticks) busy = 1'b0;
          end
        end
      endcase
      if (!busy && waiting > 0) begin
        ck = checksum16(version, LEN_BYTE, PLAY_CMD, ZERO_BYTE, folder, track_store[rd_ptr]);
        tx_frame = '{SOF_BYTE, version, LEN_BYTE, PLAY_CMD, ZERO_BYTE, folder,
                     track_store[rd_ptr], ck[15:8], ck[7:0], EOF_BYTE};
        rd_ptr  = rd_ptr + 4'd1;
        waiting = waiting - 1;
        busy    = 1'b1;
        timer   = 16'd0;
        foreach (tx_frame[i]) add_result(KIND_TX, tx_frame[i], 8'h00, 8'h00, 8'h00, 8'h00);
      end
      if (pending_results.size() > first)
        pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH %s", msg);
    endtask

    task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
    endtask

    task check_result(input result_t got);
      result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("tx_byte", got.tx_byte, want.tx_byte);
      compare_field("last", got.last, want.last);
      compare_field("rx_command", got.rx_command, want.rx_command);
      compare_field("rx_feedback", got.rx_feedback, want.rx_feedback);
      compare_field("rx_param_high", got.rx_param_high, want.rx_param_high);
      compare_field("rx_param_low", got.rx_param_low, want.rx_param_low);
      compare_field("player_busy", got.player_busy, want.player_busy);
      compare_field("queue_count", got.queue_count, want.queue_count);
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   hold_left = 0;   // cycles the receiver must still hold off, counted by the receiver

  sap_in_if                 in_ch();
  sap_out_if #(.CNT_W(5))   out_ch();
  sap_cfg_if                cfg_ch();

  frame_scoreboard sb;

  serial_audio_player_controller #(.QUEUE_DEPTH(QDEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: pick a stall pattern, keep it for a random stretch, then pick
  // again. A pending hold-off overrides the pattern until it counts down.
  initial begin : receiver
    stall_mode_e mode;
    int          left;
    mode = STALL_NONE;
    left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = $urandom_range(30, 150);
      end
      left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE:     out_ch.ready <= 1'b1;
          STALL_LIGHT:    out_ch.ready <= ($urandom_range(0, 9) < 7);
          STALL_PERIODIC: out_ch.ready <= (left % 4 != 0);
          default:        out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: every result transfer goes to the scoreboard
  always @(posedge clk) begin : monitor
    result_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.kind          = out_ch.kind;
      seen.tx_byte       = out_ch.tx_byte;
      seen.last          = out_ch.last;
      seen.rx_command    = out_ch.rx_command;
      seen.rx_feedback   = out_ch.rx_feedback;
      seen.rx_param_high = out_ch.rx_param_high;
      seen.rx_param_low  = out_ch.rx_param_low;
      seen.player_busy   = out_ch.player_busy;
      seen.queue_count   = out_ch.queue_count;
      sb.check_result(seen);
    end
  end

  // Offer one item and hold it until the transfer. Leave valid high so a
  // following item goes out on the next cycle without a bubble.
  task automatic send_item(input logic [1:0] act, input logic [7:0] trk,
                           input logic [7:0] rxb);
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.track   <= trk;
    in_ch.rx_byte <= rxb;
    do @(posedge clk); while (!in_ch.ready);
    sb.predict_item(act, trk, rxb);
  endtask

  // Drop valid to idle the input; n sets the length of the pause (n >= 1)
  task automatic pause_input(input int n);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop offering items, wait for every expected result, then let any
  // result-free items still in flight clear the pipeline.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.apply_register(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Send one frame as the player would: correct checksum, sometimes the
  // done command, sometimes led by stray bytes, sometimes with one byte hit.
  task automatic send_frame(output int count);
    logic [7:0]  b [FRAME_LEN];
    logic [15:0] ck;
    int          lead;
    int          bad;
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    bad  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, FRAME_LEN - 1) : -1;
    b[0] = SOF_BYTE;
    for (int i = 1; i < 7; i++) b[i] = 8'($urandom);
    if ($urandom_range(0, 1) == 1) b[2] = LEN_BYTE;
    if ($urandom_range(0, 1) == 1) b[3] = DONE_CMD;
    ck   = frame_scoreboard::checksum16(b[1], b[2], b[3], b[4], b[5], b[6]);
    b[7] = ck[15:8];
    b[8] = ck[7:0];
    b[9] = EOF_BYTE;
    if (bad >= 0) b[bad] = b[bad] ^ 8'($urandom_range(1, 255));
    repeat (lead) send_item(ACT_RX, 8'($urandom), 8'($urandom));
    foreach (b[i]) send_item(ACT_RX, 8'($urandom), b[i]);
    count = lead + FRAME_LEN;
  endtask

  // Random traffic in bursts; frames make up most of the items, the rest
  // is requests, ticks, stray bytes and the unused action code.
  task automatic run_random(input int target, input bit gaps);
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < target) begin
      repeat ($urandom_range(1, 5)) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          send_item(ACT_PLAY, 8'($urandom), 8'($urandom));
          sent++;
        end else if (pick < 55) begin
          send_item(ACT_TICK, 8'($urandom), 8'($urandom));
          sent++;
        end else if (pick < 85) begin
          send_frame(n);
          sent += n;
        end else if (pick < 95) begin
          send_item(ACT_RX, 8'($urandom), 8'($urandom));
          sent++;
        end else begin
          send_item(ACT_NONE, 8'($urandom), 8'($urandom));
        end
      end
      if (gaps && $urandom_range(0, 2) != 0) pause_input($urandom_range(1, 12));
    end
  endtask

  initial begin : stimulus
    int n;
    sb = new();
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_PLAY;
    in_ch.track   = 8'h00;
    in_ch.rx_byte = 8'h00;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_TIMEOUT;
    cfg_ch.data   = 16'h0000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: unused action, idle tick, a stray byte, then fill the queue
    // behind a busy player until a request is dropped.
    send_item(ACT_NONE, 8'hFF, 8'hFF);
    send_item(ACT_TICK, 8'h00, 8'h00);
    send_item(ACT_RX, 8'hFF, 8'h00);
    send_item(ACT_PLAY, 8'h00, 8'hFF);
    send_item(ACT_PLAY, 8'hFF, 8'h00);
    repeat (QDEPTH - 1) send_item(ACT_PLAY, 8'($urandom), 8'($urandom));
    send_item(ACT_PLAY, 8'($urandom), 8'($urandom));
    drain();

    // Zero timeout and zero bytes: every tick ends playback. Hold the
    // receiver off while frames pile up so the input side backs up.
    write_reg(REG_TIMEOUT, 16'h0000);
    write_reg(REG_FOLDER, 16'hFF00);
    write_reg(REG_VERSION, 16'h0000);
    hold_left = HOLD_CYCLES;
    repeat (12) begin
      send_item(ACT_PLAY, 8'($urandom), 8'($urandom));
      send_item(ACT_TICK, 8'($urandom), 8'($urandom));
    end
    drain();
    run_random(12, 1'b1);
    drain();

    // Largest timeout: the timer cannot pass it, so only a done frame frees
    // the player. Run back to back, no gaps.
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_FOLDER, 16'h00FF);
    write_reg(REG_VERSION, 16'hFFFF);
    send_item(ACT_PLAY, 8'($urandom), 8'($urandom));
    repeat (TICK_RUN) send_item(ACT_TICK, 8'($urandom), 8'($urandom));
    send_item(ACT_PLAY, 8'($urandom), 8'($urandom));
    send_frame(n);
    run_random(12, 1'b0);
    drain();

    // Short timeouts with random bytes; also poke the empty register index
    write_reg(REG_TIMEOUT, 16'd3);
    write_reg(REG_FOLDER, 16'($urandom));
    write_reg(REG_VERSION, 16'($urandom));
    write_reg(REG_NONE, 16'($urandom));
    run_random(12, 1'b1);
    drain();

    write_reg(REG_TIMEOUT, 16'd1);
    write_reg(REG_FOLDER, 16'($urandom));
    write_reg(REG_VERSION, 16'($urandom));
    run_random(12, 1'b1);
    drain();

    write_reg(REG_TIMEOUT, 16'($urandom_range(0, 8)));
    write_reg(REG_FOLDER, 16'($urandom));
    write_reg(REG_VERSION, 16'($urandom));
    run_random(12, 1'b1);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sap_pkg.sv
rtl/sap_if.sv
rtl/sap_front.sv
rtl/sap_desc_fifo.sv
rtl/sap_back.sv
rtl/serial_audio_player_controller.sv
bench/tb_top.sv
